// ===== rtl/ddd_pkg.sv =====
package ddd_pkg;

    // stream widths
    localparam int unsigned S_TDATA_W = 176;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned DIFF_W    = 23;
    localparam int unsigned SERIAL_W  = 22;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned REST_W    = 12;

    // text format
    localparam logic [7:0] DATE_LEN   = 8'd10;
    localparam logic [7:0] ASCII_DASH = 8'h2D;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FROM_BAD = 2'd1,
        STATUS_TO_BAD   = 2'd2
    } status_t;

    // one date after character decode
    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [6:0]        century;
        logic [6:0]        year_lo;
        logic [6:0]        month;
        logic [6:0]        day;
    } date_dec_t;

    // one date split into year part and remainder of the serial day
    typedef struct packed {
        logic                ok;
        logic [SERIAL_W-1:0] base;
        logic [REST_W-1:0]   rest;
    } date_part_t;

    // one date as a full serial day
    typedef struct packed {
        logic                ok;
        logic [SERIAL_W-1:0] serial;
    } date_serial_t;

    // length of a month in a common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2:                    r = 5'd28;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

    // days of the year before the first of a month
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // check format and turn the digits into numbers
    function automatic date_dec_t decode_date(input logic [39:0] hi, input logic [39:0] lo,
                                              input logic [7:0] len);
        logic [7:0] ch [10];
        logic [3:0] dg [10];
        logic       fmt;
        date_dec_t  r;
        for (int i = 0; i < 5; i++) begin
            ch[i]     = hi[39-8*i -: 8];
            ch[i + 5] = lo[39-8*i -: 8];
        end
        fmt = (len == DATE_LEN);
        for (int i = 0; i < 10; i++) begin
            if (i == 4 || i == 7) begin
                fmt = fmt && (ch[i] == ASCII_DASH);
            end else begin
                fmt = fmt && (ch[i] >= ASCII_ZERO) && (ch[i] <= ASCII_NINE);
            end
            dg[i] = ch[i][3:0];
        end
        r.ok      = fmt;
        r.year    = YEAR_W'(dg[0]) * YEAR_W'(1000) + YEAR_W'(dg[1]) * YEAR_W'(100)
                  + YEAR_W'(dg[2]) * YEAR_W'(10) + YEAR_W'(dg[3]);
        r.century = 7'(dg[0]) * 7'd10 + 7'(dg[1]);
        r.year_lo = 7'(dg[2]) * 7'd10 + 7'(dg[3]);
        r.month   = 7'(dg[5]) * 7'd10 + 7'(dg[6]);
        r.day     = 7'(dg[8]) * 7'd10 + 7'(dg[9]);
        return r;
    endfunction

    // range checks, leap days and year base
    function automatic date_part_t split_date(input date_dec_t d);
        logic              leap;
        logic              lo_nz;
        logic [4:0]        mlen;
        logic [REST_W-1:0] l4;
        logic [REST_W-1:0] l100;
        logic [REST_W-1:0] l400;
        logic [REST_W-1:0] leaps;
        logic              mon_ok;
        logic              day_ok;
        date_part_t        r;
        lo_nz  = (d.year_lo != 7'd0);
        // year divisible by 4 and not by 100, or by 400
        leap   = (lo_nz && d.year_lo[1:0] == 2'd0) || (!lo_nz && d.century[1:0] == 2'd0);
        mon_ok = (d.month >= 7'd1) && (d.month <= 7'd12);
        mlen   = (d.month[3:0] == 4'd2 && leap) ? 5'd29 : month_len(d.month[3:0]);
        day_ok = (d.day >= 7'd1) && (d.day <= 7'(mlen));
        // leap days of years before this one: ceil(y/4) - ceil(y/100) + ceil(y/400)
        l4     = REST_W'(d.year >> 2) + REST_W'(d.year[1:0] != 2'd0);
        l100   = REST_W'(d.century) + REST_W'(lo_nz);
        l400   = REST_W'(d.century >> 2) + REST_W'((d.century[1:0] != 2'd0) || lo_nz);
        leaps  = l4 - l100 + l400;
        r.ok   = d.ok && mon_ok && day_ok;
        r.base = SERIAL_W'(d.year) * SERIAL_W'(365);
        r.rest = leaps + REST_W'(days_before(d.month[3:0]))
               + REST_W'(d.month > 7'd2 && leap) + REST_W'(d.day);
        return r;
    endfunction

endpackage

// ===== rtl/date_text_day_difference.sv =====
// channel  dir  tdata fields, lowest bit up
// -------  ---  ----------------------------------------------------------------
// s_       in   from_text_high 40, from_text_low 40, from_length 8,
//               to_text_high 40, to_text_low 40, to_length 8 (176 bits)
// m_       out  day_difference 23 signed, status 2, zero pad 7 (32 bits)
//
// four register stages: character decode, range check and year multiply,
// serial day add, difference; one item per cycle while the output is not stalled
// the last stage is the output register; while a result waits, input keeps
// flowing until all four stages hold an item
// reset clears the stage valid bits only; data registers are not reset
// a stall holds each full stage whose successor is full and still lets gaps close up
module date_text_day_difference
    import ddd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // from_text_high, from_text_low, from_length, to_text_high, to_text_low, to_length
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // day_difference, status, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    // stage valid bits and the ready chain
    logic         v1_reg, v2_reg, v3_reg, v4_reg;
    logic         rdy1, rdy2, rdy3, rdy4;

    date_dec_t    dec_reg  [2];
    date_part_t   part_reg [2];
    date_serial_t ser_reg  [2];
    logic [DIFF_W-1:0] diff_reg;
    status_t      status_reg;

    date_dec_t    dec_next [2];
    date_part_t   part_next [2];
    date_serial_t ser_next [2];
    logic [DIFF_W-1:0] diff_next;
    status_t      status_next;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage logic for both dates
    always_comb begin
        dec_next[0] = decode_date(s_tdata[39:0], s_tdata[79:40], s_tdata[87:80]);
        dec_next[1] = decode_date(s_tdata[127:88], s_tdata[167:128], s_tdata[175:168]);
        for (int k = 0; k < 2; k++) begin
            part_next[k]       = split_date(dec_reg[k]);
            ser_next[k].ok     = part_reg[k].ok;
            ser_next[k].serial = part_reg[k].base + SERIAL_W'(part_reg[k].rest);
        end
    end

    // difference and status, from date checked first
    always_comb begin
        diff_next   = '0;
        status_next = STATUS_OK;
        if (!ser_reg[0].ok) begin
            status_next = STATUS_FROM_BAD;
        end else if (!ser_reg[1].ok) begin
            status_next = STATUS_TO_BAD;
        end else begin
            diff_next = DIFF_W'(ser_reg[1].serial) - DIFF_W'(ser_reg[0].serial);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy1) dec_reg  <= dec_next;
        if (rdy2) part_reg <= part_next;
        if (rdy3) ser_reg  <= ser_next;
        if (rdy4) begin
            diff_reg   <= diff_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'd0, status_reg, diff_reg};

endmodule

// ===== rtl/ddd_checker.sv =====
module ddd_checker
    import ddd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // only the three status codes appear
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:23] == STATUS_OK || m_tdata[24:23] == STATUS_FROM_BAD
                      || m_tdata[24:23] == STATUS_TO_BAD))
        else $error("bad status code");

    // a failed date gives a zero difference
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[24:23] != STATUS_OK) |-> (m_tdata[22:0] == '0))
        else $error("nonzero difference on error");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result item changed under stall");

endmodule

bind date_text_day_difference ddd_checker u_ddd_checker (.*);

// ===== verif/ddd_tb_pkg.sv =====
package ddd_tb_pkg;
    import ddd_pkg::*;

    // one expected difference result
    typedef struct {
        logic [DIFF_W-1:0] diff;
        status_t           status;
    } day_result_t;

    class day_diff_scoreboard;
        day_result_t pending_days[$];
        int          mismatches;
        int          seen_ok;
        int          seen_from_bad;
        int          seen_to_bad;

        function new();
            mismatches    = 0;
            seen_ok       = 0;
            seen_from_bad = 0;
            seen_to_bad   = 0;
        endfunction

        function int pending();
            return pending_days.size();
        endfunction

        // gregorian month length
        function int month_days(int y, int m);
            bit leap;
            int r;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (m)
                2:            r = leap ? 29 : 28;
                4, 6, 9, 11:  r = 30;
                default:      r = 31;
            endcase
            return r;
        endfunction

        // day count from 0000-01-01 as day one; returns 0 for a malformed date
        function bit serial_day(logic [79:0] txt, logic [7:0] len, output int serial);
            int         dig [10];
            logic [7:0] c;
            int         y;
            int         m;
            int         d;
            serial = 0;
            if (len != DATE_LEN) return 0;
            for (int i = 0; i < 10; i++) begin
                c = txt[79-8*i -: 8];
                if (i == 4 || i == 7) begin
                    if (c != ASCII_DASH) return 0;
                    dig[i] = 0;
                end else begin
                    if (c < ASCII_ZERO || c > ASCII_NINE) return 0;
                    dig[i] = int'(c - ASCII_ZERO);
                end
            end
            y = dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3];
            m = dig[5] * 10 + dig[6];
            d = dig[8] * 10 + dig[9];
            if (m < 1 || m > 12) return 0;
            if (d < 1 || d > month_days(y, m)) return 0;
            // leap days in years before y, year 0 counting as leap
            serial = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
            for (int k = 1; k < m; k++) begin
                serial += month_days(y, k);
            end
            return 1;
        endfunction

        // work out the result of an accepted date pair
        function void note_pair(logic [S_TDATA_W-1:0] td);
            logic [79:0] from_txt;
            logic [79:0] to_txt;
            int          from_serial;
            int          to_serial;
            day_result_t r;
            from_txt = {td[39:0], td[79:40]};
            to_txt   = {td[127:88], td[167:128]};
            r.diff   = '0;
            if (!serial_day(from_txt, td[87:80], from_serial)) begin
                r.status = STATUS_FROM_BAD;
            end else if (!serial_day(to_txt, td[175:168], to_serial)) begin
                r.status = STATUS_TO_BAD;
            end else begin
                r.status = STATUS_OK;
                r.diff   = DIFF_W'(to_serial - from_serial);
            end
            pending_days.push_back(r);
        endfunction

        // compare an accepted result with the oldest pending one
        function void check_result(logic [M_TDATA_W-1:0] td);
            day_result_t       want;
            logic [DIFF_W-1:0] got_diff;
            status_t           got_status;
            got_diff   = td[DIFF_W-1:0];
            got_status = status_t'(td[DIFF_W+1:DIFF_W]);
            if (pending_days.size() == 0) begin
                $error("unexpected result: day_difference %0d status %0d",
                       $signed(got_diff), got_status);
                mismatches++;
                return;
            end
            want = pending_days.pop_front();
            case (want.status)
                STATUS_OK:       seen_ok++;
                STATUS_FROM_BAD: seen_from_bad++;
                default:         seen_to_bad++;
            endcase
            if (got_diff !== want.diff) begin
                $error("day_difference: expected %0d, actual %0d",
                       $signed(want.diff), $signed(got_diff));
                mismatches++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got_status);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddd_pkg::*;
    import ddd_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PAIRS = 480;
    localparam int HOLD_CYCLES  = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // from_text_high, from_text_low, from_length, to_text_high, to_text_low, to_length
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // day_difference, status, zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    day_diff_scoreboard date_board;
    int                 cycles;

    date_text_day_difference u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ten characters of a string as packed text
    function automatic logic [79:0] text_of(string s);
        logic [79:0] r;
        for (int i = 0; i < 10; i++) begin
            r[79-8*i -: 8] = s[i];
        end
        return r;
    endfunction

    // text for year, month and day numbers, two digits each for month and day
    function automatic logic [79:0] date_text(int y, int m, int d);
        logic [79:0] r;
        int          dig [10];
        dig = '{y / 1000 % 10, y / 100 % 10, y / 10 % 10, y % 10, 0,
                m / 10 % 10, m % 10, 0, d / 10 % 10, d % 10};
        for (int i = 0; i < 10; i++) begin
            r[79-8*i -: 8] = (i == 4 || i == 7) ? ASCII_DASH : ASCII_ZERO + 8'(dig[i]);
        end
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pair(logic [79:0] ft, logic [7:0] fl,
                                                  logic [79:0] tt, logic [7:0] tl);
        return {tl, tt[39:0], tt[79:40], fl, ft[39:0], ft[79:40]};
    endfunction

    // one date side: mostly well formed, some corrupted or plain noise
    function automatic void random_side(output logic [79:0] txt, output logic [7:0] len);
        int y;
        int m;
        int d;
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 6))
                0:       y = 0;
                1:       y = 4;
                2:       y = 100;
                3:       y = 400;
                4:       y = 1900;
                5:       y = 2000;
                default: y = 9999;
            endcase
        end else begin
            y = $urandom_range(0, 9999);
        end
        m    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        d    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        txt  = date_text(y, m, d);
        len  = DATE_LEN;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            txt[79-8*$urandom_range(0, 9) -: 8] = 8'($urandom_range(0, 255));
        end else if (pick < 12) begin
            len = 8'($urandom_range(0, 255));
        end else if (pick < 16) begin
            txt = 80'({$urandom, $urandom, $urandom});
            len = $urandom_range(0, 1) ? DATE_LEN : 8'($urandom_range(0, 255));
        end
    endfunction

    // offer one item after a gap and wait for it to be taken
    task automatic send_item(logic [S_TDATA_W-1:0] data, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (s_tready !== 1'b1);
        date_board.note_pair(data);
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int  taken;
        int  gap;
        bit  held;
        taken    = 0;
        held     = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            gap = (taken % 60 < 20) ? 0 : $urandom_range(0, 17);
            if (!held && taken == 150) begin
                gap += HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            date_board.check_result(m_tdata);
            taken++;
        end
    end

    // run time limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // reset, directed pairs, random pairs, drain
    initial begin
        logic [S_TDATA_W-1:0] directed [$];
        logic [79:0]          ft;
        logic [79:0]          tt;
        logic [7:0]           fl;
        logic [7:0]           tl;
        int                   sent;
        date_board = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // widest span both ways, leap rules, calendar boundaries
        directed.push_back(pair(text_of("0000-01-01"), DATE_LEN, text_of("9999-12-31"), DATE_LEN));
        directed.push_back(pair(text_of("9999-12-31"), DATE_LEN, text_of("0000-01-01"), DATE_LEN));
        directed.push_back(pair(text_of("2000-02-29"), DATE_LEN, text_of("2024-02-29"), DATE_LEN));
        directed.push_back(pair(text_of("1900-02-29"), DATE_LEN, text_of("1900-03-01"), DATE_LEN));
        directed.push_back(pair(text_of("0000-02-29"), DATE_LEN, text_of("0000-03-01"), DATE_LEN));
        directed.push_back(pair(text_of("2023-02-28"), DATE_LEN, text_of("2023-02-29"), DATE_LEN));
        directed.push_back(pair(text_of("2021-00-10"), DATE_LEN, text_of("2021-01-10"), DATE_LEN));
        directed.push_back(pair(text_of("2021-12-10"), DATE_LEN, text_of("2021-13-10"), DATE_LEN));
        directed.push_back(pair(text_of("2021-05-00"), DATE_LEN, text_of("2021-05-01"), DATE_LEN));
        directed.push_back(pair(text_of("2021-12-31"), DATE_LEN, text_of("2021-04-31"), DATE_LEN));
        directed.push_back(pair(text_of("1999-12-31"), DATE_LEN, text_of("2000-01-01"), DATE_LEN));
        directed.push_back(pair(text_of("1234-05-06"), DATE_LEN, text_of("1234-05-06"), DATE_LEN));
        // length other than ten on either side
        directed.push_back(pair(text_of("2020-01-01"), 8'd9, text_of("2020-01-02"), DATE_LEN));
        directed.push_back(pair(text_of("2020-01-01"), 8'd11, text_of("2020-01-02"), DATE_LEN));
        directed.push_back(pair(text_of("2020-01-01"), 8'd255, text_of("2020-01-02"), DATE_LEN));
        directed.push_back(pair(text_of("2020-01-01"), 8'd0, text_of("2020-01-02"), DATE_LEN));
        directed.push_back(pair(text_of("2020-01-01"), DATE_LEN, text_of("2020-01-02"), 8'd9));
        // separator and digit faults, both dates bad reports the from date
        directed.push_back(pair(text_of("2021/01-01"), DATE_LEN, text_of("2021-01-01"), DATE_LEN));
        directed.push_back(pair(text_of("2021-01-01"), DATE_LEN, text_of("20a1-01-01"), DATE_LEN));
        directed.push_back(pair(text_of("2021-01:01"), DATE_LEN, text_of("2021-1x-01"), DATE_LEN));
        // digit with the top bit set is not a digit
        ft = text_of("2021-01-01");
        ft[79-8*2 -: 8] = ASCII_ZERO | 8'h80;
        directed.push_back(pair(ft, DATE_LEN, text_of("2021-01-01"), DATE_LEN));
        directed.push_back('0);
        directed.push_back('1);
        foreach (directed[i]) begin
            send_item(directed[i], (i % 3 == 0) ? $urandom_range(0, 17) : 0);
        end

        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            random_side(ft, fl);
            random_side(tt, tl);
            send_item(pair(ft, fl, tt, tl), (sent % 50 < 15) ? 0 : $urandom_range(0, 17));
            sent++;
        end
        s_tvalid <= 1'b0;

        while (date_board.pending() > 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("date pairs checked: %0d valid, %0d with bad from date, %0d with bad to date",
                 date_board.seen_ok, date_board.seen_from_bad, date_board.seen_to_bad);
        $display("stimulus: %0d directed and %0d random pairs, %0d mismatches",
                 directed.size(), RANDOM_PAIRS, date_board.mismatches);
        if (date_board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ddd_pkg.sv
rtl/date_text_day_difference.sv
rtl/ddd_checker.sv
verif/ddd_tb_pkg.sv
verif/tb.sv
